>>> hw/rtl/dds_pkg.sv
// Shared types, codes and helper functions of the disk seek timing model.
`default_nettype none
package dds_pkg;

	// Head position registers are one bit wider than the result fields so that
	// the sweep stays exact for any configured cylinder or sector count.
	localparam int unsigned POS_W = 7;

	localparam logic [2:0] CFG_CYLINDERS = 3'd0;
	localparam logic [2:0] CFG_HEADS     = 3'd1;
	localparam logic [2:0] CFG_SECTORS   = 3'd2;
	localparam logic [2:0] CFG_SEEK      = 3'd3;
	localparam logic [2:0] CFG_ROTATION  = 3'd4;
	localparam logic [2:0] CFG_TRANSFER  = 3'd5;
	localparam logic [2:0] CFG_SPIN      = 3'd6;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_PEEK  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		DS_FREE  = 2'd0,
		DS_READ  = 2'd1,
		DS_WRITE = 2'd2
	} ds_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [5:0] req_cylinder;
		logic [2:0] req_head;
		logic [5:0] req_sector;
		logic       write_value;
	} in_word_t;

	typedef struct packed {
		logic       accepted;
		logic       finished;
		logic       finished_was_read;
		logic       finished_value;
		logic       peek_value;
		logic       busy_res;
		logic [5:0] head_cylinder;
		logic [5:0] head_sector;
		logic       moving_inward;
	} out_word_t;

	// Effective configuration: geometry clamped, tick counts with zero read as one.
	typedef struct packed {
		logic [6:0]  cyl_n;
		logic [6:0]  head_n;
		logic [6:0]  sec_n;
		logic [15:0] seek_ticks;
		logic [15:0] rot_ticks;
		logic [15:0] xfer_ticks;
		logic [15:0] spin_ticks;
	} cfg_t;

	// A word as classified by the front end.
	typedef struct packed {
		op_t        kind;
		logic [5:0] cyl;
		logic [5:0] sec;
		logic       wval;
		logic       geom_ok;
		logic       peek_ok;
	} entry_t;

	function automatic logic [6:0] clamp_geom(input logic [6:0] v, input int unsigned mx);
		if (v == 7'd0) return 7'd1;
		if (32'(v) > mx) return 7'(mx);
		return v;
	endfunction

	function automatic logic [15:0] floor_ticks(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/dds_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dds_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 32768,
	localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> hw/rtl/dds_front.sv
// Front end: accepts words, classifies them and queues them for the back end.
`default_nettype none
module dds_front import dds_pkg::*; #(
	parameter int unsigned MAX_CYLINDERS = 64,
	parameter int unsigned MAX_HEADS = 8,
	parameter int unsigned MAX_SECTORS = 64,
	localparam int unsigned ADDR_W = $clog2(MAX_HEADS * MAX_CYLINDERS * MAX_SECTORS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire in_word_t          item,
	input  wire cfg_t              cfg,
	input  wire logic              clearing,
	output logic                   head_valid,
	output entry_t                 head,
	output logic      [ADDR_W-1:0] head_addr,
	input  wire logic              pop
);

	entry_t            fifo_q [2];
	logic [ADDR_W-1:0] addr_q [2];
	logic [1:0]        count_q;
	logic              wr_ptr_q;
	logic              rd_ptr_q;

	entry_t            cls;
	logic [ADDR_W-1:0] cls_addr;
	logic [31:0]       addr_full;
	logic              push;

	always_comb begin
		cls.kind    = op_t'(item.opcode);
		cls.cyl     = item.req_cylinder;
		cls.sec     = item.req_sector;
		cls.wval    = item.write_value;
		cls.geom_ok = ({1'b0, item.req_cylinder} < cfg.cyl_n) &&
			({4'b0000, item.req_head} < cfg.head_n) &&
			({1'b0, item.req_sector} < cfg.sec_n);
		cls.peek_ok = (32'(item.req_cylinder) < MAX_CYLINDERS) &&
			(32'(item.req_head) < MAX_HEADS) &&
			(32'(item.req_sector) < MAX_SECTORS);
		// Platter address is head-major, then cylinder, then sector.
		addr_full = (32'(item.req_head) * MAX_CYLINDERS + 32'(item.req_cylinder)) *
			MAX_SECTORS + 32'(item.req_sector);
		cls_addr = addr_full[ADDR_W-1:0];
	end

	assign busy       = (count_q == 2'd2) || clearing;
	assign push       = start && !busy;
	assign head_valid = (count_q != 2'd0);
	assign head       = fifo_q[rd_ptr_q];
	assign head_addr  = addr_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
			addr_q[wr_ptr_q] <= cls_addr;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/dds_back.sv
// Back end: clears the platter, then runs the drive state for each queued word.
`default_nettype none
module dds_back import dds_pkg::*; #(
	parameter int unsigned MAX_CYLINDERS = 64,
	parameter int unsigned MAX_HEADS = 8,
	parameter int unsigned MAX_SECTORS = 64,
	localparam int unsigned DEPTH = MAX_HEADS * MAX_CYLINDERS * MAX_SECTORS,
	localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              head_valid,
	input  wire entry_t            head,
	input  wire logic [ADDR_W-1:0] head_addr,
	output logic                   pop,
	output logic                   clearing,
	output logic                   done,
	output out_word_t              result
);

	typedef enum logic [2:0] {
		BK_CLEAR = 3'b001,
		BK_IDLE  = 3'b010,
		BK_EXEC  = 3'b100
	} bk_state_t;

	typedef struct packed {
		ds_t               status;
		logic [5:0]        pend_cyl;
		logic [5:0]        pend_sec;
		logic [ADDR_W-1:0] pend_addr;
		logic              pend_bit;
		logic [POS_W-1:0]  pos_cyl;
		logic [POS_W-1:0]  pos_sec;
		logic              inward;
		logic              seek_act;
		logic [15:0]       seek_cnt;
		logic              rot_act;
		logic [15:0]       rot_cnt;
		logic              xfer_act;
		logic [15:0]       xfer_cnt;
		logic              spin_act;
		logic [15:0]       spin_cnt;
	} drive_t;

	bk_state_t         state_q, state_d;
	logic [ADDR_W-1:0] clr_cnt_q;
	entry_t            item_q;
	drive_t            st_q, st_d;
	out_word_t         res_d;
	logic              done_q;
	out_word_t         result_q;

	// Address of the word in flight, kept for requests that become pending.
	logic [ADDR_W-1:0] ram_raddr_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [0:0]        ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [0:0]        ram_rdata;

	function automatic logic hits(input logic [15:0] cnt, input logic [15:0] ticks);
		return (17'(cnt) + 17'd1) >= 17'(ticks);
	endfunction

	// After reset only the spin countdown runs.
	function automatic drive_t drive_reset();
		drive_t d;
		d = '0;
		d.spin_act = 1'b1;
		return d;
	endfunction

	dds_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_platter (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign clearing  = (state_q == BK_CLEAR);
	assign pop       = (state_q == BK_IDLE) && head_valid;
	assign ram_raddr = (head.kind == OP_PEEK) ? head_addr : st_q.pend_addr;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: begin
				if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (head_valid) begin
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// One word of drive behavior; the platter bit for it was read in the idle cycle.
	always_comb begin
		drive_t    s;
		out_word_t r;
		s = st_q;
		r = '0;
		ram_we    = 1'b0;
		ram_waddr = st_q.pend_addr;
		ram_wdata = st_q.pend_bit;

		case (item_q.kind)
			OP_TICK: begin
				if (s.spin_act) begin
					if (hits(s.spin_cnt, cfg.spin_ticks)) begin
						s.spin_cnt = '0;
						if (cfg.cyl_n == 7'd1) begin
							s.inward  = 1'b0;
							s.pos_cyl = '0;
						end else begin
							if (s.pos_cyl == '0) begin
								s.inward = 1'b0;
							end else if (s.pos_cyl >= cfg.cyl_n - 7'd1) begin
								s.inward = 1'b1;
							end
							if (s.inward) begin
								s.pos_cyl = s.pos_cyl - 7'd1;
							end else begin
								s.pos_cyl = s.pos_cyl + 7'd1;
							end
						end
						if (s.pos_sec >= cfg.sec_n - 7'd1) begin
							s.pos_sec = '0;
						end else begin
							s.pos_sec = s.pos_sec + 7'd1;
						end
					end else begin
						s.spin_cnt = s.spin_cnt + 16'd1;
					end
				end

				if (s.xfer_act) begin
					if (hits(s.xfer_cnt, cfg.xfer_ticks)) begin
						s.xfer_act = 1'b0;
						s.xfer_cnt = '0;
						if (s.status == DS_READ) begin
							s.pend_bit = ram_rdata[0];
							r.finished_was_read = 1'b1;
						end else if (s.status == DS_WRITE) begin
							ram_we = 1'b1;
						end
						r.finished       = 1'b1;
						r.finished_value = s.pend_bit;
						s.status         = DS_FREE;
						s.spin_act       = 1'b1;
						s.spin_cnt       = '0;
					end else begin
						s.xfer_cnt = s.xfer_cnt + 16'd1;
					end
				end

				if (s.seek_act) begin
					if (hits(s.seek_cnt, cfg.seek_ticks)) begin
						s.seek_act = 1'b0;
						s.seek_cnt = '0;
						s.pos_cyl  = {1'b0, s.pend_cyl};
						if (s.pos_cyl == {1'b0, s.pend_cyl} &&
							s.pos_sec == {1'b0, s.pend_sec}) begin
							s.xfer_act = 1'b1;
							s.xfer_cnt = '0;
						end
					end else begin
						s.seek_cnt = s.seek_cnt + 16'd1;
					end
				end

				if (s.rot_act) begin
					if (hits(s.rot_cnt, cfg.rot_ticks)) begin
						s.rot_act = 1'b0;
						s.rot_cnt = '0;
						s.pos_sec = {1'b0, s.pend_sec};
						if (s.pos_cyl == {1'b0, s.pend_cyl} &&
							s.pos_sec == {1'b0, s.pend_sec}) begin
							s.xfer_act = 1'b1;
							s.xfer_cnt = '0;
						end
					end else begin
						s.rot_cnt = s.rot_cnt + 16'd1;
					end
				end
			end
			OP_PEEK: begin
				r.peek_value = item_q.peek_ok & ram_rdata[0];
			end
			default: begin
				// Read and write requests.
				if (s.status == DS_FREE && item_q.geom_ok) begin
					r.accepted = 1'b1;
					if (item_q.kind == OP_READ) begin
						// A read turns the sweep toward the requested cylinder.
						if (s.inward) begin
							if ({1'b0, item_q.cyl} > s.pos_cyl) begin
								s.inward = 1'b0;
							end
						end else if ({1'b0, item_q.cyl} < s.pos_cyl) begin
							s.inward = 1'b1;
						end
						s.status = DS_READ;
					end else begin
						s.pend_bit = item_q.wval;
						s.status   = DS_WRITE;
					end
					s.pend_cyl  = item_q.cyl;
					s.pend_sec  = item_q.sec;
					s.pend_addr = ram_raddr_q;
					s.spin_act  = 1'b0;
					s.spin_cnt  = '0;
					s.seek_act  = 1'b1;
					s.seek_cnt  = '0;
					s.rot_act   = 1'b1;
					s.rot_cnt   = '0;
				end
			end
		endcase

		if (state_q == BK_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = 1'b0;
		end else if (state_q != BK_EXEC) begin
			// Only a word that is being executed may write the platter.
			ram_we = 1'b0;
		end

		r.busy_res      = (s.status != DS_FREE);
		r.head_cylinder = s.pos_cyl[5:0];
		r.head_sector   = s.pos_sec[5:0];
		r.moving_inward = s.inward;
		st_d  = s;
		res_d = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_cnt_q   <= '0;
			done_q      <= 1'b0;
			st_q        <= drive_reset();
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == BK_EXEC);
			if (state_q == BK_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			end
			if (state_q == BK_EXEC) begin
				st_q <= st_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q      <= head;
			ram_raddr_q <= head_addr;
		end
		if (state_q == BK_EXEC) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

>>> hw/rtl/disk_drive_seek_timing_model.sv
// Top level of the disk seek timing model: configuration registers and the two engine halves.
// Each word is accepted when start is high and busy is low, and its result word appears
// on result with done high for one cycle. The back end pops the word from the queue in its
// idle state, where the registered platter read is made, and registers the result in its
// execute state, which does the update and the write back; a word waits longer while earlier
// words are still in the queue, and the receiver cannot hold the result off. The back end
// takes no new word before it is through with the last one; a two-word queue in the front
// end lets start be taken while the back end is still working. After reset the platter RAM
// is swept to zero one bit a cycle over all MAX_HEADS * MAX_CYLINDERS * MAX_SECTORS bits
// (32768 by default), and busy stays high until the sweep ends. Configuration writes are
// taken at any time but should only be issued while no word is in flight.
`default_nettype none
module disk_drive_seek_timing_model import dds_pkg::*; #(
	parameter int unsigned MAX_CYLINDERS = 64,
	parameter int unsigned MAX_HEADS = 8,
	parameter int unsigned MAX_SECTORS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire in_word_t    item,
	output logic             done,
	output out_word_t        result,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int unsigned ADDR_W = $clog2(MAX_HEADS * MAX_CYLINDERS * MAX_SECTORS);

	logic [6:0]  cyl_q;
	logic [3:0]  heads_q;
	logic [6:0]  sec_q;
	logic [15:0] seek_q;
	logic [15:0] rot_q;
	logic [15:0] xfer_q;
	logic [15:0] spin_q;

	cfg_t              cfg;
	logic              head_valid;
	entry_t            head;
	logic [ADDR_W-1:0] head_addr;
	logic              pop;
	logic              clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyl_q   <= 7'd5;
			heads_q <= 4'd1;
			sec_q   <= 7'd10;
			seek_q  <= 16'd1;
			rot_q   <= 16'd2;
			xfer_q  <= 16'd10;
			spin_q  <= 16'd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CYLINDERS: cyl_q   <= cfg_data[6:0];
				CFG_HEADS:     heads_q <= cfg_data[3:0];
				CFG_SECTORS:   sec_q   <= cfg_data[6:0];
				CFG_SEEK:      seek_q  <= cfg_data;
				CFG_ROTATION:  rot_q   <= cfg_data;
				CFG_TRANSFER:  xfer_q  <= cfg_data;
				CFG_SPIN:      spin_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.cyl_n      = clamp_geom(cyl_q, MAX_CYLINDERS);
		cfg.head_n     = clamp_geom({3'b000, heads_q}, MAX_HEADS);
		cfg.sec_n      = clamp_geom(sec_q, MAX_SECTORS);
		cfg.seek_ticks = floor_ticks(seek_q);
		cfg.rot_ticks  = floor_ticks(rot_q);
		cfg.xfer_ticks = floor_ticks(xfer_q);
		cfg.spin_ticks = floor_ticks(spin_q);
	end

	dds_front #(
		.MAX_CYLINDERS(MAX_CYLINDERS),
		.MAX_HEADS    (MAX_HEADS),
		.MAX_SECTORS  (MAX_SECTORS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg       (cfg),
		.clearing  (clearing),
		.head_valid(head_valid),
		.head      (head),
		.head_addr (head_addr),
		.pop       (pop)
	);

	dds_back #(
		.MAX_CYLINDERS(MAX_CYLINDERS),
		.MAX_HEADS    (MAX_HEADS),
		.MAX_SECTORS  (MAX_SECTORS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head_valid(head_valid),
		.head      (head),
		.head_addr (head_addr),
		.pop       (pop),
		.clearing  (clearing),
		.done      (done),
		.result    (result)
	);

`ifndef SYNTHESIS
	a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !done)
		else $error("result word strobed during the platter clearing sweep");

	a_results_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result words on consecutive cycles");

	a_accept_excludes_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.accepted && result.finished))
		else $error("one word both accepted a request and finished a transfer");

	a_finish_frees_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.finished) |-> !result.busy_res)
		else $error("drive still busy after a finished transfer");
`endif

endmodule
`default_nettype wire
